// ===== hw/rtl/yfd_pkg.sv =====
// Shared types, constants and saturation helpers for the 2D Yee field solver.
// No dependencies; used by yfd_mac, yee_fdtd_2d_update and the bench.
`timescale 1ns / 1ps
`default_nettype none

package yfd_pkg;

  // Field widths and default grid geometry
  localparam int DATA_W          = 32;
  localparam int POS_W           = 6;
  localparam int FUNC_W          = 2;
  localparam int COMP_W          = 4;
  localparam int CFG_ADDR_W      = 3;
  localparam int GRID_COLS_DEF   = 64;
  localparam int GRID_ROWS_DEF   = 64;
  localparam int FRAC_BITS_DEF   = 16;

  // Item functions
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd2;

  // Component codes
  localparam logic [COMP_W-1:0] COMP_EX = 4'd0;
  localparam logic [COMP_W-1:0] COMP_EY = 4'd1;
  localparam logic [COMP_W-1:0] COMP_EZ = 4'd2;
  localparam logic [COMP_W-1:0] COMP_BX = 4'd3;
  localparam logic [COMP_W-1:0] COMP_BY = 4'd4;
  localparam logic [COMP_W-1:0] COMP_BZ = 4'd5;
  localparam logic [COMP_W-1:0] COMP_JX = 4'd6;
  localparam logic [COMP_W-1:0] COMP_JY = 4'd7;
  localparam logic [COMP_W-1:0] COMP_JZ = 4'd8;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_COEF_X   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_COEF_Y   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_COEF_CUR = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_COL_STA  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_COL_END  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW_STA  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW_END  = 3'd6;

  // Memory groups (each group is three planes: x, y, z)
  localparam int G_E = 0;
  localparam int G_B = 1;
  localparam int G_J = 2;
  localparam int G_M = 3;

  // Sweep phases
  localparam logic PH_B = 1'b0;
  localparam logic PH_E = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_OPS,
    ST_WB
  } yfd_state_t;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         col;
    logic [POS_W-1:0]         row;
    logic [COMP_W-1:0]        component;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] e_x;
    logic signed [DATA_W-1:0] e_y;
    logic signed [DATA_W-1:0] e_z;
    logic signed [DATA_W-1:0] b_x;
    logic signed [DATA_W-1:0] b_y;
    logic signed [DATA_W-1:0] b_z;
    logic signed [DATA_W-1:0] b_x_mid;
    logic signed [DATA_W-1:0] b_y_mid;
    logic signed [DATA_W-1:0] b_z_mid;
  } out_t;

  // Accumulate control carried down the multiply pipe
  typedef struct packed {
    logic              sub;
    logic              start;
    logic [DATA_W-1:0] init;
    logic [1:0]        dst;
  } mac_ctl_t;

  // One product term: acc = sat((start ? init : acc) +/- mulq(diff ? sat(a-b) : a, coef))
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              diff;
    logic [DATA_W-1:0] coef;
    mac_ctl_t          ctl;
  } mac_op_t;

  // Saturate a 33-bit signed value to 32 bits
  function automatic logic [DATA_W-1:0] sat33(input logic [DATA_W:0] v);
    logic [DATA_W-1:0] r;
    if (v[DATA_W] == v[DATA_W-1]) r = v[DATA_W-1:0];
    else if (v[DATA_W]) r = {1'b1, {(DATA_W-1){1'b0}}};
    else r = {1'b0, {(DATA_W-1){1'b1}}};
    return r;
  endfunction

  // Saturate a 65-bit signed value to 32 bits
  function automatic logic [DATA_W-1:0] sat65(input logic [2*DATA_W:0] v);
    logic [DATA_W-1:0] r;
    if ((v[2*DATA_W:DATA_W-1] == '0) || (v[2*DATA_W:DATA_W-1] == '1)) r = v[DATA_W-1:0];
    else if (v[2*DATA_W]) r = {1'b1, {(DATA_W-1){1'b0}}};
    else r = {1'b0, {(DATA_W-1){1'b1}}};
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/yfd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module yfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/yfd_mac.sv =====
// Three-stage multiply-accumulate for the field update terms, Q format with
// saturation. Depends on yfd_pkg (mac_op_t, sat33, sat65).
`timescale 1ns / 1ps
`default_nettype none

module yfd_mac #(
  parameter int FRAC_BITS = yfd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire yfd_pkg::mac_op_t                     op,
  output logic [2:0][yfd_pkg::DATA_W-1:0]           res
);

  localparam int W = yfd_pkg::DATA_W;

  logic                      s1_valid_r;
  yfd_pkg::mac_ctl_t         s1_ctl_r;
  logic [W-1:0]              s1_d_r;
  logic [W-1:0]              s1_coef_r;
  logic                      s2_valid_r;
  yfd_pkg::mac_ctl_t         s2_ctl_r;
  logic signed [2*W:0]       s2_prod_r;
  logic [W-1:0]              acc_r;
  logic [2:0][W-1:0]         res_r;

  logic [W:0]                diff;
  logic signed [2*W:0]       shifted;
  logic [W-1:0]              term;
  logic [W-1:0]              base;
  logic [W:0]                sum;
  logic [W-1:0]              acc_nxt;

  // Stage 1 operand: saturated difference or the raw value
  assign diff = {op.a[W-1], op.a} - {op.b[W-1], op.b};

  // Stage 3: shift, saturate, accumulate
  assign shifted = s2_prod_r >>> FRAC_BITS;
  assign term    = yfd_pkg::sat65(shifted);
  assign base    = s2_ctl_r.start ? s2_ctl_r.init : acc_r;
  assign sum     = s2_ctl_r.sub ? ({base[W-1], base} - {term[W-1], term})
                                : ({base[W-1], base} + {term[W-1], term});
  assign acc_nxt = yfd_pkg::sat33(sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= op.valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    s1_ctl_r  <= op.ctl;
    s1_d_r    <= op.diff ? yfd_pkg::sat33(diff) : op.a;
    s1_coef_r <= op.coef;
    s2_ctl_r  <= s1_ctl_r;
    s2_prod_r <= $signed(s1_d_r) * $signed({1'b0, s1_coef_r});
    if (s2_valid_r) begin
      acc_r <= acc_nxt;
      res_r[s2_ctl_r.dst] <= acc_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ===== hw/rtl/yee_fdtd_2d_update.sv =====
// Top level of the 2D Yee leapfrog field solver: grid stores, sweep sequencer,
// configuration registers. Depends on yfd_pkg, yfd_ram, yfd_mac.
//
//   channel   ports                              beat
//   input     in_valid / in_ready / in_data      func, col, row, component, value
//   output    out_valid / out_ready / out_data   e_*, b_*, b_*_mid
//   config    cfg_we / cfg_addr / cfg_wdata      one register write, no handshake
//
// Write and invalid funcs finish in IDLE, a read passes through READ, and a time
// step runs each interior cell through RD0-RD3, OPS and WB, first in the B sweep
// and then in the E sweep, paced by the single read address shared by all planes
// and the one MAC pipe. After reset a clearing pass zeroes every store with
// in_ready low. While a result is pending, a new beat is taken no earlier than
// the cycle that result leaves; a stalled result holds in_ready low.
`timescale 1ns / 1ps
`default_nettype none

module yee_fdtd_2d_update #(
  parameter int GRID_COLS = yfd_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = yfd_pkg::GRID_ROWS_DEF,
  parameter int FRAC_BITS = yfd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire yfd_pkg::in_t                        in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output yfd_pkg::out_t                            out_data,
  input  wire logic                                cfg_we,
  input  wire logic [yfd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [yfd_pkg::DATA_W-1:0]          cfg_wdata
);

  localparam int W       = yfd_pkg::DATA_W;
  localparam int PW      = yfd_pkg::POS_W;
  localparam int CELLS   = GRID_COLS * GRID_ROWS;
  localparam int IDX_W   = $clog2(CELLS);
  localparam int COL_MAX = GRID_COLS - 1;
  localparam int ROW_MAX = GRID_ROWS - 1;
  localparam logic [3:0] B_OPS = 4'd4;
  localparam logic [3:0] E_OPS = 4'd7;

  // Configuration registers
  logic [W-1:0]  coef_x_r, coef_y_r, coef_cur_r;
  logic [PW-1:0] col_sta_r, col_end_r, row_sta_r, row_end_r;

  // Control
  yfd_pkg::yfd_state_t state_r, state_nxt;
  logic [IDX_W-1:0] clr_cnt_r;
  logic             phase_r;
  logic [PW-1:0]    col_r, row_r;
  logic [3:0]       op_cnt_r;
  logic             out_valid_r;
  logic             rd_inside_r;
  yfd_pkg::out_t    out_data_r;

  // Captured cell data
  logic [2:0][W-1:0] cap_e0_r, cap_b0_r, cap_j0_r, cap_n1_r, cap_n2_r;

  // Memory ports
  logic [3:0][2:0]        ram_we;
  logic [3:0][2:0][W-1:0] ram_wdata;
  logic [3:0][2:0][W-1:0] ram_q;
  logic [IDX_W-1:0]       raddr, waddr;

  logic              in_fire;
  logic              in_inside;
  logic [IDX_W-1:0]  in_idx, cur_idx;
  logic [PW-1:0]     cs, ce, rs, re;
  logic              step_empty;
  logic              last_row, last_col;
  logic [3:0]        op_num;
  yfd_pkg::mac_op_t  op;
  logic [2:0][W-1:0] res;
  logic [2:0][W-1:0] mid;
  logic [W:0]        mid_sum [3];

  assign in_ready  = (state_r == yfd_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign in_inside = (32'(in_data.col) < GRID_COLS) && (32'(in_data.row) < GRID_ROWS);
  assign in_idx    = IDX_W'(32'(in_data.row) * GRID_COLS) + IDX_W'(in_data.col);
  assign cur_idx   = IDX_W'(32'(row_r) * GRID_COLS) + IDX_W'(col_r);

  // Interior bounds, clamped so the stencil stays inside the grid
  assign cs = (col_sta_r == '0) ? PW'(1) : col_sta_r;
  assign rs = (row_sta_r == '0) ? PW'(1) : row_sta_r;
  assign ce = (32'(col_end_r) > COL_MAX) ? PW'(COL_MAX) : col_end_r;
  assign re = (32'(row_end_r) > ROW_MAX) ? PW'(ROW_MAX) : row_end_r;
  assign step_empty = (cs >= ce) || (rs >= re);

  assign last_row = ({1'b0, row_r} + (PW+1)'(1)) >= {1'b0, re};
  assign last_col = ({1'b0, col_r} + (PW+1)'(1)) >= {1'b0, ce};
  assign op_num   = (phase_r == yfd_pkg::PH_E) ? E_OPS : B_OPS;

  // Time-centered B from new and old values
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mid_sum[k] = {res[k][W-1], res[k]} + {cap_b0_r[k][W-1], cap_b0_r[k]};
      mid[k]     = mid_sum[k][W:1];
    end
  end

  // Grid stores: four groups of three planes
  for (genvar g = 0; g < 4; g++) begin : g_grp
    for (genvar p = 0; p < 3; p++) begin : g_pl
      yfd_ram #(
        .WIDTH (W),
        .DEPTH (CELLS)
      ) u_ram (
        .clk   (clk),
        .we    (ram_we[g][p]),
        .waddr (waddr),
        .wdata (ram_wdata[g][p]),
        .raddr (raddr),
        .rdata (ram_q[g][p])
      );
    end
  end

  yfd_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .res   (res)
  );

  // Term table for the current cell
  always_comb begin
    op = '0;
    op.valid = (state_r == yfd_pkg::ST_OPS) && (op_cnt_r < op_num);
    op.diff  = 1'b1;
    if (phase_r == yfd_pkg::PH_B) begin
      case (op_cnt_r)
        4'd0: begin
          op.a = cap_n1_r[2]; op.b = cap_e0_r[2]; op.coef = coef_y_r;
          op.ctl = '{sub: 1'b1, start: 1'b1, init: cap_b0_r[0], dst: 2'd0};
        end
        4'd1: begin
          op.a = cap_n2_r[2]; op.b = cap_e0_r[2]; op.coef = coef_x_r;
          op.ctl = '{sub: 1'b0, start: 1'b1, init: cap_b0_r[1], dst: 2'd1};
        end
        4'd2: begin
          op.a = cap_n2_r[1]; op.b = cap_e0_r[1]; op.coef = coef_x_r;
          op.ctl = '{sub: 1'b1, start: 1'b1, init: cap_b0_r[2], dst: 2'd2};
        end
        4'd3: begin
          op.a = cap_n1_r[0]; op.b = cap_e0_r[0]; op.coef = coef_y_r;
          op.ctl = '{sub: 1'b0, start: 1'b0, init: '0, dst: 2'd2};
        end
        default: op.valid = 1'b0;
      endcase
    end else begin
      case (op_cnt_r)
        4'd0: begin
          op.a = cap_b0_r[2]; op.b = cap_n1_r[2]; op.coef = coef_y_r;
          op.ctl = '{sub: 1'b0, start: 1'b1, init: cap_e0_r[0], dst: 2'd0};
        end
        4'd1: begin
          op.a = cap_j0_r[0]; op.diff = 1'b0; op.coef = coef_cur_r;
          op.ctl = '{sub: 1'b1, start: 1'b0, init: '0, dst: 2'd0};
        end
        4'd2: begin
          op.a = cap_b0_r[2]; op.b = cap_n2_r[2]; op.coef = coef_x_r;
          op.ctl = '{sub: 1'b1, start: 1'b1, init: cap_e0_r[1], dst: 2'd1};
        end
        4'd3: begin
          op.a = cap_j0_r[1]; op.diff = 1'b0; op.coef = coef_cur_r;
          op.ctl = '{sub: 1'b1, start: 1'b0, init: '0, dst: 2'd1};
        end
        4'd4: begin
          op.a = cap_b0_r[1]; op.b = cap_n2_r[1]; op.coef = coef_x_r;
          op.ctl = '{sub: 1'b0, start: 1'b1, init: cap_e0_r[2], dst: 2'd2};
        end
        4'd5: begin
          op.a = cap_b0_r[0]; op.b = cap_n1_r[0]; op.coef = coef_y_r;
          op.ctl = '{sub: 1'b1, start: 1'b0, init: '0, dst: 2'd2};
        end
        4'd6: begin
          op.a = cap_j0_r[2]; op.diff = 1'b0; op.coef = coef_cur_r;
          op.ctl = '{sub: 1'b1, start: 1'b0, init: '0, dst: 2'd2};
        end
        default: op.valid = 1'b0;
      endcase
    end
  end

  // Next state and memory port control
  always_comb begin
    state_nxt = state_r;
    raddr     = cur_idx;
    waddr     = cur_idx;
    ram_we    = '0;
    ram_wdata = '0;
    unique case (state_r)
      yfd_pkg::ST_CLEAR: begin
        waddr  = clr_cnt_r;
        ram_we = '1;
        if (clr_cnt_r == IDX_W'(CELLS - 1)) state_nxt = yfd_pkg::ST_IDLE;
      end
      yfd_pkg::ST_IDLE: begin
        raddr = in_idx;
        waddr = in_idx;
        for (int g = 0; g < 4; g++)
          for (int p = 0; p < 3; p++) ram_wdata[g][p] = in_data.value;
        if (in_fire) begin
          unique case (in_data.func)
            yfd_pkg::FUNC_WRITE: begin
              if (in_inside) begin
                case (in_data.component)
                  yfd_pkg::COMP_EX: ram_we[yfd_pkg::G_E][0] = 1'b1;
                  yfd_pkg::COMP_EY: ram_we[yfd_pkg::G_E][1] = 1'b1;
                  yfd_pkg::COMP_EZ: ram_we[yfd_pkg::G_E][2] = 1'b1;
                  yfd_pkg::COMP_BX: ram_we[yfd_pkg::G_B][0] = 1'b1;
                  yfd_pkg::COMP_BY: ram_we[yfd_pkg::G_B][1] = 1'b1;
                  yfd_pkg::COMP_BZ: ram_we[yfd_pkg::G_B][2] = 1'b1;
                  yfd_pkg::COMP_JX: ram_we[yfd_pkg::G_J][0] = 1'b1;
                  yfd_pkg::COMP_JY: ram_we[yfd_pkg::G_J][1] = 1'b1;
                  yfd_pkg::COMP_JZ: ram_we[yfd_pkg::G_J][2] = 1'b1;
                  default: ;
                endcase
              end
            end
            yfd_pkg::FUNC_READ: state_nxt = yfd_pkg::ST_READ;
            yfd_pkg::FUNC_STEP: if (!step_empty) state_nxt = yfd_pkg::ST_RD0;
            default: ;
          endcase
        end
      end
      yfd_pkg::ST_READ: state_nxt = yfd_pkg::ST_IDLE;
      yfd_pkg::ST_RD0:  state_nxt = yfd_pkg::ST_RD1;
      yfd_pkg::ST_RD1: begin
        // row neighbor: j+1 for the B sweep, j-1 for the E sweep
        raddr = (phase_r == yfd_pkg::PH_E) ? cur_idx - IDX_W'(GRID_COLS)
                                           : cur_idx + IDX_W'(GRID_COLS);
        state_nxt = yfd_pkg::ST_RD2;
      end
      yfd_pkg::ST_RD2: begin
        // column neighbor: i+1 for B, i-1 for E
        raddr = (phase_r == yfd_pkg::PH_E) ? cur_idx - IDX_W'(1) : cur_idx + IDX_W'(1);
        state_nxt = yfd_pkg::ST_RD3;
      end
      yfd_pkg::ST_RD3: state_nxt = yfd_pkg::ST_OPS;
      yfd_pkg::ST_OPS: begin
        if (op_cnt_r == op_num + 4'd1) state_nxt = yfd_pkg::ST_WB;
      end
      yfd_pkg::ST_WB: begin
        if (phase_r == yfd_pkg::PH_E) begin
          ram_we[yfd_pkg::G_E] = '1;
          ram_wdata[yfd_pkg::G_E] = res;
        end else begin
          ram_we[yfd_pkg::G_B] = '1;
          ram_we[yfd_pkg::G_M] = '1;
          ram_wdata[yfd_pkg::G_B] = res;
          ram_wdata[yfd_pkg::G_M] = mid;
        end
        if (last_row && last_col && (phase_r == yfd_pkg::PH_E)) state_nxt = yfd_pkg::ST_IDLE;
        else state_nxt = yfd_pkg::ST_RD0;
      end
      default: state_nxt = yfd_pkg::ST_IDLE;
    endcase
  end

  // State register and sweep counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= yfd_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
      phase_r   <= yfd_pkg::PH_B;
      col_r     <= '0;
      row_r     <= '0;
      op_cnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == yfd_pkg::ST_CLEAR) clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      if (state_r == yfd_pkg::ST_IDLE && in_fire) begin
        phase_r <= yfd_pkg::PH_B;
        col_r   <= cs;
        row_r   <= rs;
      end
      if (state_r == yfd_pkg::ST_RD3) op_cnt_r <= '0;
      if (state_r == yfd_pkg::ST_OPS) op_cnt_r <= op_cnt_r + 4'd1;
      if (state_r == yfd_pkg::ST_WB) begin
        if (!last_row) begin
          row_r <= row_r + PW'(1);
        end else begin
          row_r <= rs;
          if (!last_col) begin
            col_r <= col_r + PW'(1);
          end else begin
            col_r   <= cs;
            phase_r <= ~phase_r;
          end
        end
      end
    end
  end

  // Cell data capture from the registered RAM read data in RD1, RD2 and RD3
  always_ff @(posedge clk) begin
    if (state_r == yfd_pkg::ST_IDLE) rd_inside_r <= in_inside;
    if (state_r == yfd_pkg::ST_RD1) begin
      cap_e0_r <= ram_q[yfd_pkg::G_E];
      cap_b0_r <= ram_q[yfd_pkg::G_B];
      cap_j0_r <= ram_q[yfd_pkg::G_J];
    end
    if (state_r == yfd_pkg::ST_RD2)
      cap_n1_r <= (phase_r == yfd_pkg::PH_E) ? ram_q[yfd_pkg::G_B] : ram_q[yfd_pkg::G_E];
    if (state_r == yfd_pkg::ST_RD3)
      cap_n2_r <= (phase_r == yfd_pkg::PH_E) ? ram_q[yfd_pkg::G_B] : ram_q[yfd_pkg::G_E];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (state_r == yfd_pkg::ST_IDLE && in_fire &&
          !(in_data.func == yfd_pkg::FUNC_READ) &&
          !(in_data.func == yfd_pkg::FUNC_STEP && !step_empty))
        out_valid_r <= 1'b1;
      if (state_r == yfd_pkg::ST_READ) out_valid_r <= 1'b1;
      if (state_r == yfd_pkg::ST_WB && last_row && last_col && (phase_r == yfd_pkg::PH_E))
        out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == yfd_pkg::ST_IDLE && in_fire) out_data_r <= '0;
    if (state_r == yfd_pkg::ST_WB) out_data_r <= '0;
    if (state_r == yfd_pkg::ST_READ) begin
      if (rd_inside_r) begin
        out_data_r.e_x     <= ram_q[yfd_pkg::G_E][0];
        out_data_r.e_y     <= ram_q[yfd_pkg::G_E][1];
        out_data_r.e_z     <= ram_q[yfd_pkg::G_E][2];
        out_data_r.b_x     <= ram_q[yfd_pkg::G_B][0];
        out_data_r.b_y     <= ram_q[yfd_pkg::G_B][1];
        out_data_r.b_z     <= ram_q[yfd_pkg::G_B][2];
        out_data_r.b_x_mid <= ram_q[yfd_pkg::G_M][0];
        out_data_r.b_y_mid <= ram_q[yfd_pkg::G_M][1];
        out_data_r.b_z_mid <= ram_q[yfd_pkg::G_M][2];
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_x_r   <= '0;
      coef_y_r   <= '0;
      coef_cur_r <= '0;
      col_sta_r  <= PW'(1);
      col_end_r  <= PW'(63);
      row_sta_r  <= PW'(1);
      row_end_r  <= PW'(63);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        yfd_pkg::CFG_COEF_X:   coef_x_r   <= cfg_wdata;
        yfd_pkg::CFG_COEF_Y:   coef_y_r   <= cfg_wdata;
        yfd_pkg::CFG_COEF_CUR: coef_cur_r <= cfg_wdata;
        yfd_pkg::CFG_COL_STA:  col_sta_r  <= cfg_wdata[PW-1:0];
        yfd_pkg::CFG_COL_END:  col_end_r  <= cfg_wdata[PW-1:0];
        yfd_pkg::CFG_ROW_STA:  row_sta_r  <= cfg_wdata[PW-1:0];
        yfd_pkg::CFG_ROW_END:  row_end_r  <= cfg_wdata[PW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_yee_fdtd_2d_update.sv =====
// Self-checking bench for yee_fdtd_2d_update: grid writes, cell reads and time steps.
// Results are checked against a behavioral field solver kept in this file; needs yfd_pkg.
`timescale 1ns / 1ps

module tb_yee_fdtd_2d_update;

  localparam int NCOLS      = 64;
  localparam int NROWS      = 64;
  localparam int FRAC       = 16;
  localparam int PLANE      = NCOLS * NROWS;
  localparam int WDOG_LIMIT = 500000;
  localparam logic [yfd_pkg::FUNC_W-1:0] FUNC_NOP  = 2'd3;
  localparam logic [yfd_pkg::COMP_W-1:0] COMP_OVER = 4'd9;
  localparam logic [yfd_pkg::COMP_W-1:0] COMP_NONE = 4'd15;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  yfd_pkg::in_t  in_data;
  yfd_pkg::out_t out_data;
  logic cfg_we;
  logic [yfd_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [yfd_pkg::DATA_W-1:0] cfg_wdata;

  yee_fdtd_2d_update dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Solver state mirrored in the bench
  int e_grid[3*PLANE];
  int b_grid[3*PLANE];
  int j_grid[3*PLANE];
  int bmid_grid[3*PLANE];
  int unsigned dt_dx, dt_dy, dt_cur;
  int unsigned c_lo, c_hi, r_lo, r_hi;

  yfd_pkg::out_t cell_results[$];
  int   mismatches = 0;
  bit   no_idle = 1'b0;
  bit   hold_req = 1'b0;
  int   idle_cycles = 0;

  function automatic int fidx(int comp, int c, int r);
    return comp * PLANE + r * NCOLS + c;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // coefficient product, floor shift, saturate
  function automatic longint scale_q(longint d, int unsigned c);
    longint p;
    p = d * longint'(c);
    return sat32(p >>> FRAC);
  endfunction

  // one leapfrog step: B sweep then E sweep
  function automatic void advance_fields();
    int cs, ce, rs, re;
    longint ox, oy, oz, ez, nx, ny, nz, bz, ex, ey;
    cs = (c_lo < 1) ? 1 : c_lo;
    ce = (c_hi > NCOLS - 1) ? NCOLS - 1 : c_hi;
    rs = (r_lo < 1) ? 1 : r_lo;
    re = (r_hi > NROWS - 1) ? NROWS - 1 : r_hi;
    for (int i = cs; i < ce; i++)
      for (int j = rs; j < re; j++) begin
        ox = b_grid[fidx(0, i, j)];
        oy = b_grid[fidx(1, i, j)];
        oz = b_grid[fidx(2, i, j)];
        ez = e_grid[fidx(2, i, j)];
        nx = sat32(ox - scale_q(sat32(e_grid[fidx(2, i, j + 1)] - ez), dt_dy));
        ny = sat32(oy + scale_q(sat32(e_grid[fidx(2, i + 1, j)] - ez), dt_dx));
        nz = sat32(oz - scale_q(sat32(longint'(e_grid[fidx(1, i + 1, j)])
                                      - e_grid[fidx(1, i, j)]), dt_dx));
        nz = sat32(nz + scale_q(sat32(longint'(e_grid[fidx(0, i, j + 1)])
                                      - e_grid[fidx(0, i, j)]), dt_dy));
        b_grid[fidx(0, i, j)] = int'(nx);
        b_grid[fidx(1, i, j)] = int'(ny);
        b_grid[fidx(2, i, j)] = int'(nz);
        bmid_grid[fidx(0, i, j)] = int'((nx + ox) >>> 1);
        bmid_grid[fidx(1, i, j)] = int'((ny + oy) >>> 1);
        bmid_grid[fidx(2, i, j)] = int'((nz + oz) >>> 1);
      end
    for (int i = cs; i < ce; i++)
      for (int j = rs; j < re; j++) begin
        bz = b_grid[fidx(2, i, j)];
        ex = e_grid[fidx(0, i, j)];
        ey = e_grid[fidx(1, i, j)];
        ez = e_grid[fidx(2, i, j)];
        ex = sat32(ex + scale_q(sat32(bz - b_grid[fidx(2, i, j - 1)]), dt_dy));
        ex = sat32(ex - scale_q(j_grid[fidx(0, i, j)], dt_cur));
        ey = sat32(ey - scale_q(sat32(bz - b_grid[fidx(2, i - 1, j)]), dt_dx));
        ey = sat32(ey - scale_q(j_grid[fidx(1, i, j)], dt_cur));
        ez = sat32(ez + scale_q(sat32(longint'(b_grid[fidx(1, i, j)])
                                      - b_grid[fidx(1, i - 1, j)]), dt_dx));
        ez = sat32(ez - scale_q(sat32(longint'(b_grid[fidx(0, i, j)])
                                      - b_grid[fidx(0, i, j - 1)]), dt_dy));
        ez = sat32(ez - scale_q(j_grid[fidx(2, i, j)], dt_cur));
        e_grid[fidx(0, i, j)] = int'(ex);
        e_grid[fidx(1, i, j)] = int'(ey);
        e_grid[fidx(2, i, j)] = int'(ez);
      end
  endfunction

  // apply one item to the mirrored grid and return the result beat it should give
  function automatic yfd_pkg::out_t solve_item(yfd_pkg::in_t it);
    yfd_pkg::out_t r;
    int c;
    r = '0;
    c = it.component;
    case (it.func)
      yfd_pkg::FUNC_WRITE: begin
        if (c < 3) e_grid[fidx(c, it.col, it.row)] = it.value;
        else if (c < 6) b_grid[fidx(c - 3, it.col, it.row)] = it.value;
        else if (c < 9) j_grid[fidx(c - 6, it.col, it.row)] = it.value;
      end
      yfd_pkg::FUNC_READ: begin
        r.e_x = e_grid[fidx(0, it.col, it.row)];
        r.e_y = e_grid[fidx(1, it.col, it.row)];
        r.e_z = e_grid[fidx(2, it.col, it.row)];
        r.b_x = b_grid[fidx(0, it.col, it.row)];
        r.b_y = b_grid[fidx(1, it.col, it.row)];
        r.b_z = b_grid[fidx(2, it.col, it.row)];
        r.b_x_mid = bmid_grid[fidx(0, it.col, it.row)];
        r.b_y_mid = bmid_grid[fidx(1, it.col, it.row)];
        r.b_z_mid = bmid_grid[fidx(2, it.col, it.row)];
      end
      yfd_pkg::FUNC_STEP: advance_fields();
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    return no_idle ? 0 : $urandom_range(0, 12);
  endfunction

  // send one beat; called right after a rising edge, returns at its acceptance edge
  task automatic send_item(yfd_pkg::in_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    cell_results.push_back(solve_item(it));
  endtask

  task automatic send_fields(logic [yfd_pkg::FUNC_W-1:0] f, int c, int r,
                             logic [yfd_pkg::COMP_W-1:0] comp, int v);
    yfd_pkg::in_t it;
    it.func = f;
    it.col = c[yfd_pkg::POS_W-1:0];
    it.row = r[yfd_pkg::POS_W-1:0];
    it.component = comp;
    it.value = v;
    send_item(it);
  endtask

  // drain the result queue before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (cell_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [yfd_pkg::CFG_ADDR_W-1:0] a, logic [yfd_pkg::DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    @(posedge clk);
    case (a)
      yfd_pkg::CFG_COEF_X:   dt_dx  = d;
      yfd_pkg::CFG_COEF_Y:   dt_dy  = d;
      yfd_pkg::CFG_COEF_CUR: dt_cur = d;
      yfd_pkg::CFG_COL_STA:  c_lo   = d[5:0];
      yfd_pkg::CFG_COL_END:  c_hi   = d[5:0];
      yfd_pkg::CFG_ROW_STA:  r_lo   = d[5:0];
      yfd_pkg::CFG_ROW_END:  r_hi   = d[5:0];
      default: ;
    endcase
  endtask

  task automatic set_all(int unsigned kx, int unsigned ky, int unsigned kj,
                         int cs, int ce, int rs, int re);
    wait_idle();
    write_reg(yfd_pkg::CFG_COEF_X, kx);
    write_reg(yfd_pkg::CFG_COEF_Y, ky);
    write_reg(yfd_pkg::CFG_COEF_CUR, kj);
    write_reg(yfd_pkg::CFG_COL_STA, cs);
    write_reg(yfd_pkg::CFG_COL_END, ce);
    write_reg(yfd_pkg::CFG_ROW_STA, rs);
    write_reg(yfd_pkg::CFG_ROW_END, re);
    cfg_we <= 1'b0;
  endtask

  function automatic int rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return $urandom;
      default: return int'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
    endcase
  endfunction

  // Result checker
  always @(posedge clk) begin
    yfd_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (cell_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_data);
      end else begin
        want = cell_results.pop_front();
        for (int k = 0; k < 9; k++)
          if (want[k*32 +: 32] !== out_data[k*32 +: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d (from b_z_mid up): expected %h, got %h",
                       k, want[k*32 +: 32], out_data[k*32 +: 32]);
          end
      end
    end
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("FAIL yee_fdtd_2d_update");
      $finish;
    end
  end

  // Result receiver with random stalls and an optional long hold-off
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic test_cell_access();
    // empty store, corner extremes, every component, ignored codes
    send_fields(yfd_pkg::FUNC_READ, 0, 0, yfd_pkg::COMP_EX, 0);
    for (int c = 0; c < 9; c++)
      send_fields(yfd_pkg::FUNC_WRITE, 63, 63, c[yfd_pkg::COMP_W-1:0],
                  (c % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF);
    send_fields(yfd_pkg::FUNC_WRITE, 0, 0, yfd_pkg::COMP_EZ, 32'hFFFF_FFFF);
    send_fields(yfd_pkg::FUNC_WRITE, 0, 0, COMP_OVER, 32'h1234_5678);
    send_fields(yfd_pkg::FUNC_WRITE, 0, 0, COMP_NONE, 32'h1234_5678);
    send_fields(FUNC_NOP, 63, 0, COMP_NONE, 32'hFFFF_FFFF);
    send_fields(yfd_pkg::FUNC_READ, 63, 63, yfd_pkg::COMP_EX, 0);
    send_fields(yfd_pkg::FUNC_READ, 0, 0, yfd_pkg::COMP_EX, 0);
  endtask

  task automatic test_full_step();
    // default interior, one full sweep of the grid with saturating data
    set_all(32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_8000, 1, 63, 1, 63);
    send_fields(yfd_pkg::FUNC_WRITE, 62, 62, yfd_pkg::COMP_EZ, 32'h8000_0000);
    send_fields(yfd_pkg::FUNC_WRITE, 62, 61, yfd_pkg::COMP_EX, 32'h7FFF_FFFF);
    send_fields(yfd_pkg::FUNC_WRITE, 1, 1, yfd_pkg::COMP_JZ, 32'h0010_0000);
    send_fields(yfd_pkg::FUNC_STEP, 0, 0, yfd_pkg::COMP_EX, 0);
    send_fields(yfd_pkg::FUNC_READ, 62, 62, yfd_pkg::COMP_EX, 0);
    send_fields(yfd_pkg::FUNC_READ, 62, 61, yfd_pkg::COMP_EX, 0);
    send_fields(yfd_pkg::FUNC_READ, 1, 1, yfd_pkg::COMP_EX, 0);
  endtask

  // small interiors with random data around the stencil
  task automatic test_random_steps();
    int cs, ce, rs, re, c, r, f;
    for (int ph = 0; ph < 5; ph++) begin
      no_idle = (ph == 2);
      case (ph)
        0: begin cs = 0; ce = 2; rs = 62; re = 63; end
        1: begin cs = 62; ce = 63; rs = 0; re = 3; end
        2: begin cs = 10; ce = 10; rs = 5; re = 8; end
        default: begin
          cs = $urandom_range(0, 58); ce = cs + $urandom_range(1, 4);
          rs = $urandom_range(0, 58); re = rs + $urandom_range(1, 4);
        end
      endcase
      set_all(ph == 0 ? 32'h0 : $urandom, ph == 1 ? 32'hFFFF_FFFF : $urandom,
              ph == 4 ? 32'h0 : $urandom_range(0, 32'h0002_0000), cs, ce, rs, re);
      for (int n = 0; n < 14; n++) begin
        c = $urandom_range(cs == 0 ? 0 : cs - 1, ce);
        r = $urandom_range(rs == 0 ? 0 : rs - 1, re);
        f = $urandom_range(0, 9);
        if (f < 5)
          send_fields(yfd_pkg::FUNC_WRITE, c, r, $urandom_range(0, 8), rand_value());
        else if (f < 8)
          send_fields(yfd_pkg::FUNC_READ, c, r, yfd_pkg::COMP_EX, 0);
        else if (f < 9)
          send_fields(yfd_pkg::FUNC_STEP, $urandom, $urandom, $urandom, $urandom);
        else
          send_fields($urandom_range(0, 1) ? FUNC_NOP : yfd_pkg::FUNC_WRITE, $urandom,
                      $urandom, $urandom_range(9, 15), $urandom);
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_output_stall();
    // receiver holds off while the sender keeps going
    wait_idle();
    hold_req = 1'b1;
    no_idle = 1'b1;
    for (int n = 0; n < 12; n++)
      send_fields(n % 2 ? yfd_pkg::FUNC_READ : yfd_pkg::FUNC_WRITE, $urandom, $urandom,
                  $urandom_range(0, 8), rand_value());
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    for (int k = 0; k < 3 * PLANE; k++) begin
      e_grid[k] = 0; b_grid[k] = 0; j_grid[k] = 0; bmid_grid[k] = 0;
    end
    dt_dx = 0; dt_dy = 0; dt_cur = 0;
    c_lo = 1; c_hi = 63; r_lo = 1; r_hi = 63;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_cell_access();
    test_full_step();
    test_random_steps();
    test_output_stall();

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && cell_results.size() == 0) begin
      $display("PASS yee_fdtd_2d_update");
    end else begin
      $display("FAIL yee_fdtd_2d_update");
    end
    $finish;
  end

endmodule
